// ===== hw/rtl/mtpl_pkg.sv =====
// shared types and constants of the mesh triangle point locator
// no dependencies
`timescale 1ns / 1ps
package mtpl_pkg;
    localparam int MAX_ELEMS = 1024;
    localparam int IDX_W     = $clog2(MAX_ELEMS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int TOL_W     = 25;
    localparam int BND_W     = 40;
    localparam int NUM_CORNERS = 3;
    localparam int PIPE_LAT  = 6;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef enum logic {
        REG_ELEM_COUNT = 1'b0,
        REG_TOLERANCE  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] t;
    } t_row;

    typedef struct packed {
        t_req               req_type;
        logic [IDX_W-1:0]   elem_index;
        logic [1:0]         corner;
        t_row               row;
        logic signed [31:0] scale;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_cmd;
endpackage

// ===== hw/rtl/mesh_triangle_point_locator_unit.sv =====
// mesh triangle point locator: a write gives no result word
// a query scans n elements, fewer on an early match
// throughput is one element per cycle, set by the three corner lanes and ram read
// queries are handled one at a time; start is taken while the 2-word queue has room
// reset (synchronous, active low) clears control and registers; the table is not cleared
// result words last one cycle on o_valid and cannot be stalled
`timescale 1ns / 1ps
module mesh_triangle_point_locator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [9:0]  i_elem_index,
    input  logic [1:0]  i_corner,
    input  logic signed [31:0] i_coef_a,
    input  logic signed [31:0] i_coef_b,
    input  logic signed [31:0] i_coef_t,
    input  logic signed [31:0] i_elem_scale,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    // result channel
    output logic        o_valid,
    output logic        o_found,
    output logic [10:0] o_elem_number,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mtpl_pkg::*;

    logic [CNT_W-1:0] r_elem_count;
    logic [TOL_W-1:0] r_tolerance;
    t_cmd             w_cmd_in, w_cmd;
    logic             w_avail, w_take, w_push;
    t_reg_idx         w_reg;

    assign pready = 1'b1;
    // byte address 4*i, register index in bit 2
    assign w_reg  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= '0;
            r_tolerance  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_ELEM_COUNT: r_elem_count <= pwdata[CNT_W-1:0];
                REG_TOLERANCE:  r_tolerance  <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_ELEM_COUNT: prdata = 32'(r_elem_count);
            REG_TOLERANCE:  prdata = 32'(r_tolerance);
            default:        prdata = '0;
        endcase
    end

    // pack the command word
    always_comb begin
        w_cmd_in.req_type   = t_req'(i_req_type);
        w_cmd_in.elem_index = i_elem_index;
        w_cmd_in.corner     = i_corner;
        w_cmd_in.row.a      = i_coef_a;
        w_cmd_in.row.b      = i_coef_b;
        w_cmd_in.row.t      = i_coef_t;
        w_cmd_in.scale      = i_elem_scale;
        w_cmd_in.x          = i_point_x;
        w_cmd_in.y          = i_point_y;
    end

    assign w_push = start && !busy;

    mtpl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_cmd(w_cmd_in),
        .o_full(busy), .i_take(w_take), .o_avail(w_avail), .o_cmd(w_cmd)
    );

    mtpl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(w_avail), .i_cmd(w_cmd),
        .o_take(w_take), .i_elem_count(r_elem_count), .i_tolerance(r_tolerance),
        .o_valid(o_valid), .o_found(o_found), .o_elem_number(o_elem_number)
    );
endmodule

// ===== hw/rtl/mtpl_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module mtpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/mtpl_front.sv =====
// front end: accepts command words into a two-entry queue
// depends on mtpl_pkg
`timescale 1ns / 1ps
module mtpl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtpl_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_take,
    output logic          o_avail,
    output mtpl_pkg::t_cmd o_cmd
);
    import mtpl_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_take);
        end
    end
endmodule

// ===== hw/rtl/mtpl_corner.sv =====
// one corner lane: five-stage barycentric value and bound test
// depends on mtpl_pkg
`timescale 1ns / 1ps
module mtpl_corner (
    input  logic                            i_clk,
    input  mtpl_pkg::t_row                  i_row,
    input  logic signed [31:0]              i_scale,
    input  logic signed [31:0]              i_x,
    input  logic signed [31:0]              i_y,
    input  logic signed [mtpl_pkg::BND_W-1:0] i_lo,
    input  logic signed [mtpl_pkg::BND_W-1:0] i_hi,
    output logic                            o_ok
);
    import mtpl_pkg::*;

    // stage 1: products
    logic signed [63:0] r_bx, r_ay;
    logic signed [31:0] r_t1, r_sc1;
    // stage 2: magnitude and sign
    logic [63:0] r_mag;
    logic [31:0] r_smag;
    logic        r_neg2;
    // stage 3: partial products
    logic [63:0] r_p1, r_p0;
    logic        r_neg3;
    // stage 4: combined magnitude
    logic [61:0] r_r;
    logic        r_fail, r_neg4;

    logic signed [65:0] n_sum;
    logic [65:0]        n_abs;
    logic [63:0]        n_r;
    logic signed [62:0] n_v;
    logic signed [38:0] n_q;

    always_comb begin
        n_sum = $signed({{2{r_bx[63]}}, r_bx}) + $signed({{2{r_ay[63]}}, r_ay})
              + $signed({{18{r_t1[31]}}, r_t1, 16'b0});
        n_abs = n_sum[65] ? 66'(-n_sum) : 66'(n_sum);
        n_r   = {r_p1[29:0], 32'b0} + r_p0;
        n_v   = r_neg4 ? -$signed({1'b0, r_r}) : $signed({1'b0, r_r});
        n_q   = 39'(n_v >>> 24);
    end

    always_ff @(posedge i_clk) begin
        r_bx   <= 64'(i_row.b * i_x);
        r_ay   <= 64'(i_row.a * i_y);
        r_t1   <= i_row.t;
        r_sc1  <= i_scale;

        r_mag  <= n_abs[63:0];
        r_smag <= r_sc1[31] ? 32'(-r_sc1) : 32'(r_sc1);
        r_neg2 <= n_sum[65] ^ r_sc1[31];

        r_p1   <= r_mag[63:32] * r_smag;
        r_p0   <= r_mag[31:0] * r_smag;
        r_neg3 <= r_neg2;

        r_r    <= n_r[61:0];
        r_fail <= (r_p1 >= 64'(1 << 30)) || n_r[63] || n_r[62];
        r_neg4 <= r_neg3;

        o_ok   <= !r_fail && ($signed({n_q[38], n_q}) >= i_lo)
                          && ($signed({n_q[38], n_q}) <= i_hi);
    end
endmodule

// ===== hw/rtl/mtpl_back.sv =====
// back end: table writes and the element scan
// depends on mtpl_pkg, mtpl_ram, mtpl_corner
`timescale 1ns / 1ps
module mtpl_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_avail,
    input  mtpl_pkg::t_cmd              i_cmd,
    output logic                        o_take,
    input  logic [mtpl_pkg::CNT_W-1:0]  i_elem_count,
    input  logic [mtpl_pkg::TOL_W-1:0]  i_tolerance,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [mtpl_pkg::CNT_W-1:0]  o_elem_number
);
    import mtpl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_j, r_n;
    logic signed [31:0]  r_x, r_y;
    logic [PIPE_LAT-1:0] r_pv;
    logic [IDX_W-1:0]    r_pidx [PIPE_LAT];
    logic                r_valid, r_found;
    logic [CNT_W-1:0]    r_num;

    t_row                w_row [NUM_CORNERS];
    logic [NUM_CORNERS-1:0] w_ok;
    logic [31:0]         w_scale;
    logic                w_issue, w_hit, w_write;
    logic signed [BND_W-1:0] w_lo, w_hi;

    assign o_take  = (r_state == ST_IDLE) && i_avail;
    assign w_write = o_take && (i_cmd.req_type == REQ_WRITE);
    assign w_issue = (r_state == ST_SCAN) && (r_j < r_n);
    assign w_hit   = r_pv[PIPE_LAT-1] && (&w_ok);
    assign w_lo    = -$signed(BND_W'(i_tolerance));
    assign w_hi    = $signed(BND_W'(i_tolerance)) + $signed(BND_W'(1 << 24));

    mtpl_ram #(.WIDTH(32), .DEPTH(MAX_ELEMS)) u_scale_ram (
        .i_clk(i_clk), .i_we(w_write && (i_cmd.corner < 2'(NUM_CORNERS))),
        .i_waddr(i_cmd.elem_index), .i_wdata(i_cmd.scale),
        .i_raddr(r_j[IDX_W-1:0]), .o_rdata(w_scale)
    );

    for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_lane
        mtpl_ram #(.WIDTH($bits(t_row)), .DEPTH(MAX_ELEMS)) u_row_ram (
            .i_clk(i_clk), .i_we(w_write && (i_cmd.corner == 2'(k))),
            .i_waddr(i_cmd.elem_index), .i_wdata(i_cmd.row),
            .i_raddr(r_j[IDX_W-1:0]), .o_rdata(w_row[k])
        );
        mtpl_corner u_corner (
            .i_clk(i_clk), .i_row(w_row[k]), .i_scale(w_scale),
            .i_x(r_x), .i_y(r_y), .i_lo(w_lo), .i_hi(w_hi), .o_ok(w_ok[k])
        );
    end

    always_ff @(posedge i_clk) begin
        r_pidx[0] <= r_j[IDX_W-1:0];
        for (int i = 1; i < PIPE_LAT; i++) begin
            r_pidx[i] <= r_pidx[i-1];
        end
        if (o_take) begin
            r_x <= i_cmd.x;
            r_y <= i_cmd.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= '0;
            r_n     <= '0;
            r_pv    <= '0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_num   <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_pv <= '0;
                    if (o_take && (i_cmd.req_type == REQ_QUERY)) begin
                        r_j     <= '0;
                        r_n     <= (i_elem_count > CNT_W'(MAX_ELEMS)) ? CNT_W'(MAX_ELEMS)
                                                                      : i_elem_count;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_pv <= {r_pv[PIPE_LAT-2:0], w_issue};
                    if (w_issue) begin
                        r_j <= r_j + 1'b1;
                    end
                    if (w_hit) begin
                        // first match wins, flush what is still in flight
                        r_valid <= 1'b1;
                        r_found <= 1'b1;
                        r_num   <= CNT_W'(r_pidx[PIPE_LAT-1]) + 1'b1;
                        r_pv    <= '0;
                        r_state <= ST_IDLE;
                    end else if (!w_issue && (r_pv == '0)) begin
                        r_valid <= 1'b1;
                        r_found <= 1'b0;
                        r_num   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_found       = r_found;
    assign o_elem_number = r_num;
endmodule

// ===== dv/tb_mesh_triangle_point_locator_unit.sv =====
// self-checking testbench of the mesh triangle point locator unit
// depends on mtpl_pkg and mesh_triangle_point_locator_unit
`timescale 1ns / 1ps
module tb_mesh_triangle_point_locator_unit;
    import mtpl_pkg::*;

    typedef struct {
        logic        found;
        logic [10:0] number;
    } t_hit;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_req_type = 1'b0;
    logic [9:0]  i_elem_index = '0;
    logic [1:0]  i_corner = '0;
    logic signed [31:0] i_coef_a = '0, i_coef_b = '0, i_coef_t = '0, i_elem_scale = '0;
    logic signed [31:0] i_point_x = '0, i_point_y = '0;
    logic        o_valid, o_found;
    logic [10:0] o_elem_number;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mesh_triangle_point_locator_unit dut (.*);

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the element table and registers
    int          tab_a[3*MAX_ELEMS], tab_b[3*MAX_ELEMS], tab_t[3*MAX_ELEMS];
    int          tab_scale[MAX_ELEMS];
    logic [10:0] cfg_count = '0;
    logic [24:0] cfg_tol = '0;

    // triangle vertices as loaded, used to aim query points
    int vx[MAX_ELEMS][3], vy[MAX_ELEMS][3];
    int loaded = 0;

    t_cmd cmd_q[$];
    t_hit hit_q[$];
    t_cmd cur;
    int   idle_pct = 0;
    int   n_err = 0, n_query = 0, n_write = 0, n_found = 0, quiet = 0;

    // exact barycentric test of one corner against [-tol, 1+tol] in Q8.24
    function automatic logic corner_in(int e, int k, logic signed [31:0] x,
                                       logic signed [31:0] y);
        logic signed [127:0] a, b, t, sc, px, py, sum, prod, lo, hi;
        a = tab_a[e*3+k];
        b = tab_b[e*3+k];
        t = tab_t[e*3+k];
        sc = tab_scale[e];
        px = x;
        py = y;
        sum = b*px + a*py + (t <<< 16);
        prod = sum * sc;
        lo = -($signed({103'd0, cfg_tol}) <<< 24);
        hi = ($signed(128'd16777217) + $signed({103'd0, cfg_tol})) <<< 24;
        return (prod >= lo) && (prod < hi);
    endfunction

    function automatic t_hit locate(logic signed [31:0] x, logic signed [31:0] y);
        t_hit h;
        int   n;
        h.found = 1'b0;
        h.number = '0;
        n = (cfg_count > MAX_ELEMS) ? MAX_ELEMS : cfg_count;
        for (int e = 0; e < n; e++) begin
            if (corner_in(e, 0, x, y) && corner_in(e, 1, x, y) && corner_in(e, 2, x, y)) begin
                h.found = 1'b1;
                h.number = 11'(e + 1);
                return h;
            end
        end
        return h;
    endfunction

    // update shadow table or queue the expected result word
    function automatic void take_word(t_cmd c);
        if (c.req_type == REQ_WRITE) begin
            n_write++;
            if (c.corner != 2'd3) begin
                tab_a[c.elem_index*3 + c.corner] = c.row.a;
                tab_b[c.elem_index*3 + c.corner] = c.row.b;
                tab_t[c.elem_index*3 + c.corner] = c.row.t;
                tab_scale[c.elem_index] = c.scale;
            end
        end else begin
            n_query++;
            hit_q.push_back(locate(c.x, c.y));
        end
    endfunction

    function automatic t_cmd rand_cmd(t_req r);
        t_cmd c;
        c.req_type = r;
        c.elem_index = 10'($urandom);
        c.corner = 2'($urandom);
        c.row.a = $urandom;
        c.row.b = $urandom;
        c.row.t = $urandom;
        c.scale = $urandom;
        c.x = $urandom;
        c.y = $urandom;
        return c;
    endfunction

    // three corner rows of a fresh random triangle with small integer vertices
    task automatic load_tri(int e);
        int   area2;
        t_cmd c;
        do begin
            for (int k = 0; k < 3; k++) begin
                vx[e][k] = $urandom_range(40) - 20;
                vy[e][k] = $urandom_range(40) - 20;
            end
            area2 = (vx[e][1]-vx[e][0])*(vy[e][2]-vy[e][0])
                  - (vx[e][2]-vx[e][0])*(vy[e][1]-vy[e][0]);
        end while (area2 == 0);
        for (int k = 0; k < 3; k++) begin
            int i, j;
            i = (k + 1) % 3;
            j = (k + 2) % 3;
            c = rand_cmd(REQ_WRITE);
            c.elem_index = 10'(e);
            c.corner = 2'(k);
            c.row.t = (vx[e][i]*vy[e][j] - vx[e][j]*vy[e][i]) <<< 16;
            c.row.b = (vy[e][i] - vy[e][j]) <<< 16;
            c.row.a = (vx[e][j] - vx[e][i]) <<< 16;
            c.scale = 65536 / area2;
            cmd_q.push_back(c);
        end
    endtask

    // query aimed inside element e, with a little jitter around the edges
    task automatic query_in(int e);
        t_cmd c;
        int   w[3], ws, sx, sy;
        c = rand_cmd(REQ_QUERY);
        ws = 0;
        sx = 0;
        sy = 0;
        for (int k = 0; k < 3; k++) begin
            w[k] = $urandom_range(255);
            ws += w[k];
            sx += w[k] * vx[e][k];
            sy += w[k] * vy[e][k];
        end
        if (ws == 0) begin
            ws = 1;
            sx = vx[e][0];
            sy = vy[e][0];
        end
        c.x = (sx * 65536) / ws + int'($urandom_range(4095)) - 2048;
        c.y = (sy * 65536) / ws + int'($urandom_range(4095)) - 2048;
        cmd_q.push_back(c);
    endtask

    // random mix: mostly aimed queries, some rewrites, some noise
    task automatic random_items(int n, int span);
        t_cmd c;
        int   r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 62) begin
                query_in($urandom_range(span - 1));
            end else if (r < 72) begin
                cmd_q.push_back(rand_cmd(REQ_QUERY));
            end else if (r < 80) begin
                c = rand_cmd(REQ_QUERY);
                c.x = ($urandom_range(50) - 25) <<< 16;
                c.y = 32'($urandom_range(3276800)) - 32'sd1638400;
                cmd_q.push_back(c);
            end else if (r < 90) begin
                load_tri($urandom_range(loaded - 1));
            end else if (r < 95) begin
                // random row content into a loaded element
                c = rand_cmd(REQ_WRITE);
                c.elem_index = 10'($urandom_range(loaded - 1));
                c.corner = 2'($urandom_range(2));
                cmd_q.push_back(c);
            end else begin
                // corner three is dropped by the block
                c = rand_cmd(REQ_WRITE);
                c.corner = 2'd3;
                cmd_q.push_back(c);
                i--;
            end
        end
    endtask

    task automatic reg_write(t_reg_idx r, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (r == REG_ELEM_COUNT) cfg_count = v[10:0];
        else cfg_tol = v[24:0];
    endtask

    // wait until every word went in and every result came out, then let writes settle
    task automatic drain();
        while (cmd_q.size() != 0 || start || hit_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // command driver: one word in flight on the ports, refilled after acceptance
    always @(posedge i_clk) begin : drv
        logic go;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            go = start;
            if (start && !busy) begin
                take_word(cur);
                go = 1'b0;
            end
            if (!go && cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cur = cmd_q.pop_front();
                i_req_type <= cur.req_type;
                i_elem_index <= cur.elem_index;
                i_corner <= cur.corner;
                i_coef_a <= cur.row.a;
                i_coef_b <= cur.row.b;
                i_coef_t <= cur.row.t;
                i_elem_scale <= cur.scale;
                i_point_x <= cur.x;
                i_point_y <= cur.y;
                go = 1'b1;
            end
            start <= go;
        end
    end

    // result monitor: every word is compared with the oldest expectation
    always @(posedge i_clk) begin : mon
        t_hit h;
        if (i_rst_n && o_valid) begin
            if (hit_q.size() == 0) begin
                $error("result word with nothing expected: found %0d number %0d",
                       o_found, o_elem_number);
                n_err++;
            end else begin
                h = hit_q.pop_front();
                if (h.found) n_found++;
                if (o_found !== h.found) begin
                    $error("found: expected %0d actual %0d", h.found, o_found);
                    n_err++;
                end
                if (o_elem_number !== h.number) begin
                    $error("elem_number: expected %0d actual %0d", h.number, o_elem_number);
                    n_err++;
                end
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || psel) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= 6000) begin
            $display("tb_mesh_triangle_point_locator_unit failed");
            $finish;
        end
    end

    initial begin : seq
        t_cmd c;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty scan: nothing can be found
        reg_write(REG_ELEM_COUNT, 32'd0);
        reg_write(REG_TOLERANCE, 32'd0);
        for (int e = 0; e < 8; e++) load_tri(e);
        loaded = 8;
        cmd_q.push_back(rand_cmd(REQ_QUERY));
        query_in(0);
        drain();

        // directed: extremes, ignored corner, last scale wins
        reg_write(REG_ELEM_COUNT, 32'd8);
        c = rand_cmd(REQ_WRITE);
        c.corner = 2'd3;
        c.elem_index = 10'd0;
        c.row.a = 32'sh7fffffff;
        c.row.b = 32'sh80000000;
        c.row.t = 32'sh7fffffff;
        c.scale = 32'sh80000000;
        cmd_q.push_back(c);
        for (int k = 0; k < 3; k++) begin
            c.elem_index = 10'd5;
            c.corner = 2'(k);
            c.row.a = k[0] ? 32'sh80000000 : 32'sh7fffffff;
            c.row.b = k[0] ? 32'sh7fffffff : 32'sh80000000;
            c.row.t = 32'sh80000000;
            c.scale = k[1] ? 32'sh7fffffff : 32'sh80000000;
            cmd_q.push_back(c);
        end
        c = rand_cmd(REQ_WRITE);
        c.elem_index = 10'd1;
        c.corner = 2'd2;
        c.row.a = tab_a[0];
        cmd_q.push_back(c);
        load_tri(1);
        c.scale = 32'sd0;
        c.corner = 2'd0;
        c.row.a = 32'sd0;
        c.row.b = 32'sd0;
        c.row.t = 32'sd0;
        c.elem_index = 10'd6;
        cmd_q.push_back(c);
        for (int k = 0; k < 4; k++) begin
            c = rand_cmd(REQ_QUERY);
            c.x = k[0] ? 32'sh7fffffff : 32'sh80000000;
            c.y = k[1] ? 32'sh7fffffff : 32'sh80000000;
            cmd_q.push_back(c);
        end
        c.x = 32'sd0;
        c.y = 32'sd0;
        cmd_q.push_back(c);
        for (int e = 0; e < 8; e++) query_in(e);
        drain();
        random_items(140, 8);
        drain();

        // widest slack, sender gaps about half the time
        reg_write(REG_TOLERANCE, 32'd16777216);
        idle_pct = 51;
        random_items(130, 8);
        drain();

        // odd count and near-full slack, light gaps
        reg_write(REG_ELEM_COUNT, 32'd5);
        reg_write(REG_TOLERANCE, 32'h0FFFFFF);
        idle_pct = 20;
        random_items(130, 5);
        drain();

        // full table, scanned at the limit and beyond it
        idle_pct = 0;
        for (int e = loaded; e < MAX_ELEMS; e++) load_tri(e);
        loaded = MAX_ELEMS;
        drain();
        reg_write(REG_ELEM_COUNT, 32'd1024);
        reg_write(REG_TOLERANCE, 32'd0);
        for (int i = 0; i < 3; i++) query_in($urandom_range(1023));
        cmd_q.push_back(rand_cmd(REQ_QUERY));
        drain();
        reg_write(REG_ELEM_COUNT, 32'd2047);
        reg_write(REG_TOLERANCE, 32'd4096);
        for (int i = 0; i < 3; i++) query_in($urandom_range(1023));
        drain();

        // medium table, mixed gaps
        reg_write(REG_ELEM_COUNT, 32'd64);
        reg_write(REG_TOLERANCE, 32'd100000);
        idle_pct = 51;
        random_items(120, 64);
        drain();

        $display("covered %0d queries (%0d found) and %0d row writes", n_query, n_found,
                 n_write);
        $display("counts 0 to 2047 scanned, slack 0 to one, with and without sender gaps");
        if (n_err == 0) begin
            $display("tb_mesh_triangle_point_locator_unit passed");
        end else begin
            $display("tb_mesh_triangle_point_locator_unit failed");
        end
        $finish;
    end
endmodule
